// ----- hw/rtl/gpio_port_register_block_assert.svh -----
// ----------------------------------------------------------------------------
// GPIO port register block assertion macros
// Shorthand for the clocked, reset-qualified properties of the port block.
// ----------------------------------------------------------------------------
`ifndef GPIO_PORT_REGISTER_BLOCK_ASSERT_SVH
`define GPIO_PORT_REGISTER_BLOCK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPIO_PRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPIO_PRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gpio_prb_pkg.sv -----
// ----------------------------------------------------------------------------
// GPIO port register block package
// Register map codes, reset constants and the structs passed between modules.
// ----------------------------------------------------------------------------
package gpio_prb_pkg;

  localparam int unsigned PinCount = 16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [2:0] REG_CFG_LOW  = 3'd0;
  localparam logic [2:0] REG_CFG_HIGH = 3'd1;
  localparam logic [2:0] REG_INPUT    = 3'd2;
  localparam logic [2:0] REG_OUTPUT   = 3'd3;
  localparam logic [2:0] REG_SET_RST  = 3'd4;
  localparam logic [2:0] REG_RESET    = 3'd5;
  localparam logic [2:0] REG_LOCK     = 3'd6;

  localparam logic [31:0] CFG_RESET_WORD = 32'h4444_4444;
  localparam int unsigned LOCK_KEY_POS   = 16;

  typedef struct packed {
    logic        command;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } access_t;

  typedef struct packed {
    logic [15:0] mask;
    logic        engaged;
    logic        engaged_next;
  } lock_status_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic [63:0] pad_config;
    logic        lock_active;
  } result_t;

  // Spread eight lock bits over eight 4-bit configuration nibbles.
  function automatic logic [31:0] nibble_mask(input logic [7:0] bits8);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[4*i +: 4] = {4{bits8[i]}};
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/gpio_port_register_block.sv -----
// An accepted request waits in the request register; its result is registered
// in the result register when the output can take it.
// Throughput: one request per cycle unless the output stalls; the request and
// result registers hold one entry each; both sides may stall without a bubble.
// Reset: synchronous; configuration words return to all pins floating inputs,
// output data, lock bits, key sequence and the engaged lock clear.
// ----------------------------------------------------------------------------
// GPIO port register block
// Stream front end of a 16-pin port: request register, register file access
// and result register.
// ----------------------------------------------------------------------------
module gpio_port_register_block (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] write_data, [47:32] pin_levels
  input  logic [47:0]  s_axis_tdata,
  // [0] command, [3:1] reg_index
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] read_data, [47:32] pin_drive, [111:48] pad_config,
  // [112] lock_active, [119:113] zero
  output logic [119:0] m_axis_tdata
);
  import gpio_prb_pkg::*;

  logic         req_valid;
  access_t      req;
  logic         fire;
  lock_status_t lock;
  result_t      res_next;
  result_t      res;

  assign fire          = req_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !req_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.command    <= s_axis_tuser[0];
      req.reg_index  <= s_axis_tuser[3:1];
      req.write_data <= s_axis_tdata[31:0];
      req.pin_levels <= s_axis_tdata[47:32];
    end
  end

  gpio_prb_lock u_lock (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .acc    (req),
    .status (lock)
  );

  gpio_prb_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .acc    (req),
    .lock   (lock),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {7'd0, res.lock_active, res.pad_config, res.pin_drive,
                         res.read_data};

`include "gpio_port_register_block_assert.svh"

  `GPIO_PRB_ASSERT_NEXT(a_lock_sticky, lock.engaged, lock.engaged, "lock disengaged before reset")
  `GPIO_PRB_ASSERT_NEXT(a_lock_mask_frozen, lock.engaged, $stable(lock.mask), "locked pin mask changed")
  `GPIO_PRB_ASSERT_NEXT(a_result_loaded, fire, m_axis_tvalid, "processed request produced no result")
  `GPIO_PRB_ASSERT_SAME(a_ready_when_empty, !req_valid, s_axis_tready, "empty request stage refused a request")

endmodule

// ----- hw/rtl/gpio_prb_lock.sv -----
// ----------------------------------------------------------------------------
// GPIO port lock sequencer
// Tracks the write 1, write 0, write 1, read key sequence on the lock register
// and holds the lock bits and the engaged flag until reset.
// ----------------------------------------------------------------------------
module gpio_prb_lock (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  gpio_prb_pkg::access_t      acc,
  output gpio_prb_pkg::lock_status_t status
);
  import gpio_prb_pkg::*;

  localparam logic [1:0] LOCK_IDLE  = 2'd0;
  localparam logic [1:0] LOCK_KEY1  = 2'd1;
  localparam logic [1:0] LOCK_KEY0  = 2'd2;
  localparam logic [1:0] LOCK_ARMED = 2'd3;

  logic [15:0] mask;
  logic [15:0] mask_next;
  logic [1:0]  step;
  logic [1:0]  step_next;
  logic        engaged;
  logic        engaged_next;

  logic        hit;
  logic        key;
  logic        same_bits;

  assign hit       = fire && (acc.reg_index == REG_LOCK) && !engaged;
  assign key       = acc.write_data[LOCK_KEY_POS];
  assign same_bits = (acc.write_data[15:0] == mask);

  always_comb begin
    mask_next    = mask;
    step_next    = step;
    engaged_next = engaged;
    if (hit && acc.command == CMD_WRITE) begin
      mask_next = acc.write_data[15:0];
      case (step)
        LOCK_IDLE: step_next = key ? LOCK_KEY1 : LOCK_IDLE;
        LOCK_KEY1: step_next = (!key && same_bits) ? LOCK_KEY0 : LOCK_IDLE;
        LOCK_KEY0: step_next = (key && same_bits) ? LOCK_ARMED : LOCK_IDLE;
        // A write where the closing read was due aborts the sequence.
        default:   step_next = LOCK_IDLE;
      endcase
    end else if (hit && step == LOCK_ARMED) begin
      engaged_next = 1'b1;
      step_next    = LOCK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      step    <= LOCK_IDLE;
      engaged <= 1'b0;
    end else begin
      mask    <= mask_next;
      step    <= step_next;
      engaged <= engaged_next;
    end
  end

  assign status.mask         = mask;
  assign status.engaged      = engaged;
  assign status.engaged_next = engaged_next;

endmodule

// ----- hw/rtl/gpio_prb_regs.sv -----
// ----------------------------------------------------------------------------
// GPIO port data and configuration registers
// Holds the pin configuration and output data registers, applies one access
// and forms the result of that access.
// ----------------------------------------------------------------------------
module gpio_prb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  gpio_prb_pkg::access_t      acc,
  input  gpio_prb_pkg::lock_status_t lock,
  output gpio_prb_pkg::result_t      result
);
  import gpio_prb_pkg::*;

  logic [31:0] cfg_low;
  logic [31:0] cfg_low_next;
  logic [31:0] cfg_high;
  logic [31:0] cfg_high_next;
  logic [15:0] out_word;
  logic [15:0] out_word_next;

  logic [31:0] frozen_low;
  logic [31:0] frozen_high;
  logic [31:0] rdata;
  logic        is_write;

  assign is_write    = (acc.command == CMD_WRITE);
  assign frozen_low  = lock.engaged ? nibble_mask(lock.mask[7:0])  : '0;
  assign frozen_high = lock.engaged ? nibble_mask(lock.mask[15:8]) : '0;

  always_comb begin
    cfg_low_next  = cfg_low;
    cfg_high_next = cfg_high;
    out_word_next = out_word;
    if (is_write) begin
      case (acc.reg_index)
        REG_CFG_LOW:
          cfg_low_next = (cfg_low & frozen_low) | (acc.write_data & ~frozen_low);
        REG_CFG_HIGH:
          cfg_high_next = (cfg_high & frozen_high) | (acc.write_data & ~frozen_high);
        REG_OUTPUT:
          out_word_next = acc.write_data[15:0];
        // Set wins over reset for the same bit.
        REG_SET_RST:
          out_word_next = (out_word & ~acc.write_data[31:16]) | acc.write_data[15:0];
        REG_RESET:
          out_word_next = out_word & ~acc.write_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata = '0;
    if (!is_write) begin
      case (acc.reg_index)
        REG_CFG_LOW:  rdata = cfg_low;
        REG_CFG_HIGH: rdata = cfg_high;
        REG_INPUT:    rdata = {16'd0, acc.pin_levels};
        REG_OUTPUT:   rdata = {16'd0, out_word};
        // The engaged bit reads as it stood before this access.
        REG_LOCK:     rdata = {15'd0, lock.engaged, lock.mask};
        default:      rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_low  <= CFG_RESET_WORD;
      cfg_high <= CFG_RESET_WORD;
      out_word <= '0;
    end else if (fire) begin
      cfg_low  <= cfg_low_next;
      cfg_high <= cfg_high_next;
      out_word <= out_word_next;
    end
  end

  assign result.read_data   = rdata;
  assign result.pin_drive   = out_word_next;
  assign result.pad_config  = {cfg_high_next, cfg_low_next};
  assign result.lock_active = lock.engaged_next;

endmodule
